// ----- src/tsfi_pkg.sv -----
// shared types and constants of the triangle surface force integrator
`default_nettype none

package tsfi_pkg;

  localparam int COORD_W      = 16;
  localparam int TRAC_W       = 16;
  localparam int EDGE_W       = COORD_W + 1;
  localparam int CROSS_W      = 2 * EDGE_W + 1;
  localparam int MAG_W        = CROSS_W - 1;
  localparam int HALF_W       = MAG_W / 2;
  localparam int SQ_PROD_W    = MAG_W + HALF_W;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int REM_W        = ROOT_W + 2;
  localparam int TSUM_W       = TRAC_W + 2;
  localparam int MUL_A_W      = CROSS_W;
  localparam int MUL_B_W      = TSUM_W;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int ACC_W        = 64;
  localparam int LANES        = 3;
  localparam int CROSS_TERMS  = 2 * LANES;
  localparam int SQUARE_TERMS = 2 * LANES;
  localparam int ROOT_STEPS   = ROOT_W;
  localparam int DIVISOR      = 6;
  localparam int DIV_DIGIT_W  = 8;
  localparam int DIV_STEPS    = ACC_W / DIV_DIGIT_W;
  localparam int DIV_REM_W    = 3;
  localparam int STEP_W       = 6;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic signed [TRAC_W-1:0]  traction_x;
    logic signed [TRAC_W-1:0]  traction_y;
    logic signed [TRAC_W-1:0]  traction_z;
    logic                      last_vertex;
  } vertex_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] force_x;
    logic signed [ACC_W-1:0] force_y;
    logic signed [ACC_W-1:0] force_z;
    logic                    saturated;
  } force_out_t;

endpackage

`default_nettype wire

// ----- src/triangle_surface_force_integrator_top.sv -----
// triangle surface force integrator: vertex gather, area by integer root, saturating sums
// a first or second vertex leaves in_ready high unless it is a last vertex; a third
// vertex keeps in_ready low through the cross, square, root and scale steps, using one
// shared 35x18 multiplier and a one-bit-per-cycle root loop
// a last vertex goes on to the divide and emit states (after scale for a third vertex)
// synchronous active-low reset clears the sequencer, slot, accumulators and clip flag
`default_nettype none

module triangle_surface_force_integrator_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tsfi_pkg::vertex_in_t in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tsfi_pkg::force_out_t      out_data
);

  import tsfi_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CROSS  = 7'b0000010,
    ST_SQUARE = 7'b0000100,
    ST_ROOT   = 7'b0001000,
    ST_SCALE  = 7'b0010000,
    ST_DIVIDE = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  localparam logic [STEP_W-1:0] CROSS_LAST  = STEP_W'(CROSS_TERMS);
  localparam logic [STEP_W-1:0] SQUARE_LAST = STEP_W'(SQUARE_TERMS);
  localparam logic [STEP_W-1:0] ROOT_LAST   = STEP_W'(ROOT_STEPS - 1);
  localparam logic [STEP_W-1:0] SCALE_LAST  = STEP_W'(LANES);
  localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(DIV_STEPS);

  function automatic logic [MAG_W-1:0] cross_mag(input logic signed [CROSS_W-1:0] v);
    cross_mag = v[CROSS_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  state_t                     state_r, state_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [STEP_W-1:0]          tag;
  logic [1:0]                 slot_r;
  logic                       last_r;
  logic                       accept;
  logic                       emit_fire;

  logic signed [COORD_W-1:0]  vin_p [LANES];
  logic signed [TRAC_W-1:0]   vin_t [LANES];
  logic signed [COORD_W-1:0]  cur_r [LANES];
  logic signed [COORD_W-1:0]  held_r [2][LANES];
  logic signed [TSUM_W-1:0]   tsum_r [LANES];
  logic signed [EDGE_W-1:0]   e1 [LANES];
  logic signed [EDGE_W-1:0]   e2 [LANES];

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic [MAG_W-1:0]           sq_mag;

  logic signed [CROSS_W-1:0]  cross_first_r;
  logic signed [CROSS_W-1:0]  cross_r [LANES];
  logic [SQ_W-1:0]            sumsq_r;
  logic [SQ_W-1:0]            sq_term;
  logic [REM_W-1:0]           rem_r;
  logic [ROOT_W-1:0]          root_r;
  logic [REM_W+1:0]           root_t;
  logic [REM_W+1:0]           root_trial;

  logic signed [ACC_W-1:0]    acc_r [LANES];
  logic signed [ACC_W-1:0]    acc_sel;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [ACC_W-1:0]    acc_sat;
  logic                       acc_ovf;
  logic                       clip_r;

  logic [ACC_W-1:0]           nq_r [LANES];
  logic                       neg_r [LANES];
  logic [DIV_REM_W-1:0]       drem_r [LANES];
  logic [ACC_W-1:0]           div_nq_nxt [LANES];
  logic [DIV_REM_W-1:0]       div_rem_nxt [LANES];
  logic [DIV_REM_W-1:0]       div_r;
  logic [DIV_REM_W:0]         div_w;
  logic [DIV_DIGIT_W-1:0]     div_q;
  logic                       sat_r;

  logic                       out_valid_r;
  force_out_t                 out_r;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign tag       = step_r - STEP_W'(1);

  assign vin_p[0] = in_data.vertex_x;
  assign vin_p[1] = in_data.vertex_y;
  assign vin_p[2] = in_data.vertex_z;
  assign vin_t[0] = in_data.traction_x;
  assign vin_t[1] = in_data.traction_y;
  assign vin_t[2] = in_data.traction_z;

  // edge vectors against the closing vertex
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      e1[k] = EDGE_W'(held_r[0][k]) - EDGE_W'(cur_r[k]);
      e2[k] = EDGE_W'(held_r[1][k]) - EDGE_W'(cur_r[k]);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    sq_mag = '0;
    case (state_r)
      ST_CROSS: begin
        case (step_r[2:0])
          3'd0: begin mul_a = MUL_A_W'(e1[1]); mul_b = MUL_B_W'(e2[2]); end
          3'd1: begin mul_a = MUL_A_W'(e2[1]); mul_b = MUL_B_W'(e1[2]); end
          3'd2: begin mul_a = MUL_A_W'(e2[0]); mul_b = MUL_B_W'(e1[2]); end
          3'd3: begin mul_a = MUL_A_W'(e1[0]); mul_b = MUL_B_W'(e2[2]); end
          3'd4: begin mul_a = MUL_A_W'(e1[0]); mul_b = MUL_B_W'(e2[1]); end
          3'd5: begin mul_a = MUL_A_W'(e2[0]); mul_b = MUL_B_W'(e1[1]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_SQUARE: begin
        case (step_r[2:1])
          2'd0:    sq_mag = cross_mag(cross_r[0]);
          2'd1:    sq_mag = cross_mag(cross_r[1]);
          2'd2:    sq_mag = cross_mag(cross_r[2]);
          default: sq_mag = '0;
        endcase
        mul_a = MUL_A_W'({1'b0, sq_mag});
        mul_b = step_r[0] ? MUL_B_W'({1'b0, sq_mag[MAG_W-1:HALF_W]})
                          : MUL_B_W'({1'b0, sq_mag[HALF_W-1:0]});
      end
      ST_SCALE: begin
        mul_a = MUL_A_W'({1'b0, root_r});
        case (step_r[1:0])
          2'd0:    mul_b = MUL_B_W'(tsum_r[0]);
          2'd1:    mul_b = MUL_B_W'(tsum_r[1]);
          2'd2:    mul_b = MUL_B_W'(tsum_r[2]);
          default: mul_b = '0;
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // square partial products, high half weighted by 2^17
  assign sq_term = tag[0] ? {prod_r[SQ_PROD_W-1:0], {HALF_W{1'b0}}}
                          : {{HALF_W{1'b0}}, prod_r[SQ_PROD_W-1:0]};

  // root digit
  assign root_t     = {rem_r, sumsq_r[SQ_W-1 -: 2]};
  assign root_trial = (REM_W+2)'({root_r, 2'b01});

  // saturating accumulate for the lane being scaled
  always_comb begin
    case (tag[1:0])
      2'd0:    acc_sel = acc_r[0];
      2'd1:    acc_sel = acc_r[1];
      2'd2:    acc_sel = acc_r[2];
      default: acc_sel = '0;
    endcase
    prod_ext = ACC_W'(prod_r);
    acc_sum  = acc_sel + prod_ext;
    acc_ovf  = (acc_sel[ACC_W-1] == prod_ext[ACC_W-1]) &&
               (acc_sum[ACC_W-1] != acc_sel[ACC_W-1]);
    if (acc_ovf) begin
      acc_sat = acc_sel[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum;
    end
  end

  // divide by six, one byte of quotient per lane per cycle
  always_comb begin
    div_r = '0;
    div_w = '0;
    div_q = '0;
    for (int k = 0; k < LANES; k++) begin
      div_r = drem_r[k];
      div_q = '0;
      for (int i = 0; i < DIV_DIGIT_W; i++) begin
        div_w = {div_r, nq_r[k][ACC_W-1-i]};
        if (div_w >= (DIV_REM_W+1)'(DIVISOR)) begin
          div_q[DIV_DIGIT_W-1-i] = 1'b1;
          div_w = div_w - (DIV_REM_W+1)'(DIVISOR);
        end
        div_r = div_w[DIV_REM_W-1:0];
      end
      div_nq_nxt[k]  = {nq_r[k][ACC_W-DIV_DIGIT_W-1:0], div_q};
      div_rem_nxt[k] = div_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + STEP_W'(1);
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          if (slot_r[1]) begin
            state_nxt = ST_CROSS;
          end else if (in_data.last_vertex) begin
            state_nxt = ST_DIVIDE;
          end
        end
      end
      ST_CROSS: begin
        if (step_r == CROSS_LAST) begin
          state_nxt = ST_SQUARE;
          step_nxt  = '0;
        end
      end
      ST_SQUARE: begin
        if (step_r == SQUARE_LAST) begin
          state_nxt = ST_ROOT;
          step_nxt  = '0;
        end
      end
      ST_ROOT: begin
        if (step_r == ROOT_LAST) begin
          state_nxt = ST_SCALE;
          step_nxt  = '0;
        end
      end
      ST_SCALE: begin
        if (step_r == SCALE_LAST) begin
          state_nxt = last_r ? ST_DIVIDE : ST_IDLE;
          step_nxt  = '0;
        end
      end
      ST_DIVIDE: begin
        if (step_r == DIV_LAST) begin
          state_nxt = ST_EMIT;
          step_nxt  = '0;
        end
      end
      ST_EMIT: begin
        step_nxt = '0;
        if (emit_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // vertex intake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      last_r <= 1'b0;
    end else if (accept) begin
      last_r <= in_data.last_vertex;
      for (int k = 0; k < LANES; k++) begin
        cur_r[k] <= vin_p[k];
      end
      if (slot_r[1]) begin
        slot_r <= '0;
        for (int k = 0; k < LANES; k++) begin
          tsum_r[k] <= tsum_r[k] + TSUM_W'(vin_t[k]);
        end
      end else begin
        slot_r <= in_data.last_vertex ? 2'd0 : slot_r + 2'd1;
        for (int k = 0; k < LANES; k++) begin
          held_r[slot_r[0]][k] <= vin_p[k];
          tsum_r[k] <= slot_r[0] ? tsum_r[k] + TSUM_W'(vin_t[k]) : TSUM_W'(vin_t[k]);
        end
      end
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // cross product, squares and root
  always_ff @(posedge clk) begin
    case (state_r)
      ST_CROSS: begin
        if (step_r != '0) begin
          if (!tag[0]) begin
            cross_first_r <= prod_r[CROSS_W-1:0];
          end else begin
            cross_r[tag[2:1]] <= cross_first_r - prod_r[CROSS_W-1:0];
          end
        end
        if (step_r == CROSS_LAST) begin
          sumsq_r <= '0;
        end
      end
      ST_SQUARE: begin
        if (step_r != '0) begin
          sumsq_r <= sumsq_r + sq_term;
        end
        if (step_r == SQUARE_LAST) begin
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      ST_ROOT: begin
        sumsq_r <= sumsq_r << 2;
        if (root_t >= root_trial) begin
          rem_r  <= REM_W'(root_t - root_trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= REM_W'(root_t);
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      default: begin
        sumsq_r <= sumsq_r;
      end
    endcase
  end

  // accumulators and divide lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= 1'b0;
      for (int k = 0; k < LANES; k++) begin
        acc_r[k] <= '0;
      end
    end else if (state_r == ST_SCALE && step_r != '0) begin
      acc_r[tag[1:0]] <= acc_sat;
      if (acc_ovf) begin
        clip_r <= 1'b1;
      end
    end else if (state_r == ST_DIVIDE) begin
      if (step_r == '0) begin
        sat_r  <= clip_r;
        clip_r <= 1'b0;
        for (int k = 0; k < LANES; k++) begin
          neg_r[k]  <= acc_r[k][ACC_W-1];
          nq_r[k]   <= acc_r[k][ACC_W-1] ? ACC_W'(-acc_r[k]) : acc_r[k];
          drem_r[k] <= '0;
          acc_r[k]  <= '0;
        end
      end else begin
        for (int k = 0; k < LANES; k++) begin
          nq_r[k]   <= div_nq_nxt[k];
          drem_r[k] <= div_rem_nxt[k];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_r.force_x   <= neg_r[0] ? -$signed(nq_r[0]) : $signed(nq_r[0]);
      out_r.force_y   <= neg_r[1] ? -$signed(nq_r[1]) : $signed(nq_r[1]);
      out_r.force_z   <= neg_r[2] ? -$signed(nq_r[2]) : $signed(nq_r[2]);
      out_r.saturated <= sat_r;
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("vertex slot out of range");

  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && step_r == ROOT_LAST) |=> (rem_r <= REM_W'({root_r, 1'b0})))
    else $error("root remainder above bound");

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE && step_r == '0) |=>
      (acc_r[0] == '0 && acc_r[1] == '0 && acc_r[2] == '0 && !clip_r))
    else $error("accumulators not cleared on result");

  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");
`endif

endmodule

`default_nettype wire
